// ===== rtl/tbr_pkg.sv =====
// Shared types, constants and arithmetic helpers for the triangle bounding-box rasterizer.
package tbr_pkg;

    localparam int COORD_W    = 9;
    localparam int COLOR_W    = 24;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int EDGE_W     = PROD_W + 2;
    localparam int NUM_VERT   = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = COLOR_W;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 48;

    typedef logic [COORD_W-1:0]          coord_t;
    typedef logic [COLOR_W-1:0]          color_t;
    typedef logic [CFG_IDX_W-1:0]        cfg_idx_t;
    typedef logic signed [DIFF_W-1:0]    diff_t;
    typedef logic signed [DIFF_W:0]      diff_sum_t;
    typedef logic signed [PROD_W-1:0]    prod_t;
    typedef logic signed [EDGE_W-1:0]    edge_t;

    localparam cfg_idx_t REG_VERTEX0_X  = 3'd0;
    localparam cfg_idx_t REG_VERTEX0_Y  = 3'd1;
    localparam cfg_idx_t REG_VERTEX1_X  = 3'd2;
    localparam cfg_idx_t REG_VERTEX1_Y  = 3'd3;
    localparam cfg_idx_t REG_VERTEX2_X  = 3'd4;
    localparam cfg_idx_t REG_VERTEX2_Y  = 3'd5;
    localparam cfg_idx_t REG_FILL_COLOR = 3'd6;

    // Edge k runs from vertex EDGE_A_IDX[k] to vertex EDGE_C_IDX[k].
    localparam int unsigned EDGE_A_IDX [NUM_VERT] = '{1, 2, 0};
    localparam int unsigned EDGE_C_IDX [NUM_VERT] = '{2, 0, 1};

    typedef struct packed {
        coord_t x;
        coord_t y;
    } vertex_t;

    typedef struct packed {
        vertex_t [NUM_VERT-1:0] v;
        color_t                 color;
    } tri_cfg_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        logic   last;
    } pixel_pos_t;

    typedef struct packed {
        prod_t     pa;
        prod_t     pb;
        prod_t     c1;
        prod_t     c2;
        diff_sum_t ab_sum;
    } edge_terms_t;

    typedef struct packed {
        pixel_pos_t                 pos;
        edge_terms_t [NUM_VERT-1:0] edges;
        prod_t                      d_pa;
        prod_t                      d_pb;
    } edge_stage_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        logic   covered;
        color_t color;
        logic   last;
    } pixel_out_t;

    function automatic diff_t to_signed(input coord_t a);
        return $signed({1'b0, a});
    endfunction

    function automatic diff_t coord_diff(input coord_t a, input coord_t b);
        return to_signed(a) - to_signed(b);
    endfunction

    function automatic prod_t mul(input diff_t a, input diff_t b);
        return a * b;
    endfunction

    function automatic edge_t edge_sum(input prod_t pa, input prod_t pb,
                                       input prod_t c1, input prod_t c2);
        return EDGE_W'(pa) + EDGE_W'(pb) + EDGE_W'(c1) - EDGE_W'(c2);
    endfunction

    function automatic edge_t edge_offscreen(input prod_t c1, input prod_t c2,
                                             input diff_sum_t ab_sum);
        return EDGE_W'(c1) - EDGE_W'(c2) - EDGE_W'(ab_sum);
    endfunction

    // An edge passes when its value agrees in sign with the opposite-vertex value;
    // on a zero value the offscreen point settles the tie.
    function automatic logic edge_ok(input edge_t e, input edge_t d, input edge_t off);
        logic e_pos;
        logic e_neg;
        logic d_pos;
        logic d_neg;
        logic o_pos;
        logic o_neg;
        e_neg = e[EDGE_W-1];
        e_pos = !e_neg && (e != '0);
        d_neg = d[EDGE_W-1];
        d_pos = !d_neg && (d != '0);
        o_neg = off[EDGE_W-1];
        o_pos = !o_neg && (off != '0);
        if ((e_neg && d_pos) || (e_pos && d_neg)) begin
            return 1'b0;
        end
        if ((e == '0) && ((d_pos && o_neg) || (d_neg && o_pos))) begin
            return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic coord_t min3(input coord_t a, input coord_t b, input coord_t c);
        coord_t m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic coord_t max3(input coord_t a, input coord_t b, input coord_t c);
        coord_t m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

endpackage

// ===== rtl/tbr_cfg_regs.sv =====
// Configuration register file holding the three vertices and the fill color.
module tbr_cfg_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  tbr_pkg::cfg_idx_t                   cfg_wr_index,
    input  logic [tbr_pkg::CFG_DATA_W-1:0]      cfg_wr_data,
    output tbr_pkg::tri_cfg_t                   cfg
);

    tbr_pkg::tri_cfg_t cfg_reg;
    tbr_pkg::tri_cfg_t cfg_next;
    tbr_pkg::coord_t   wr_coord;

    assign wr_coord = cfg_wr_data[tbr_pkg::COORD_W-1:0];

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                tbr_pkg::REG_VERTEX0_X:  cfg_next.v[0].x = wr_coord;
                tbr_pkg::REG_VERTEX0_Y:  cfg_next.v[0].y = wr_coord;
                tbr_pkg::REG_VERTEX1_X:  cfg_next.v[1].x = wr_coord;
                tbr_pkg::REG_VERTEX1_Y:  cfg_next.v[1].y = wr_coord;
                tbr_pkg::REG_VERTEX2_X:  cfg_next.v[2].x = wr_coord;
                tbr_pkg::REG_VERTEX2_Y:  cfg_next.v[2].y = wr_coord;
                tbr_pkg::REG_FILL_COLOR: cfg_next.color = cfg_wr_data[tbr_pkg::COLOR_W-1:0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/tbr_walker.sv =====
// Bounding-box walker that picks the next pixel for each accepted step request.
module tbr_walker #(
    parameter int IMAGE_WIDTH  = 512,
    parameter int IMAGE_HEIGHT = 512
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  tbr_pkg::tri_cfg_t       cfg,
    input  logic                    in_valid,
    input  logic                    in_restart,
    output logic                    in_ready,
    output logic                    out_valid,
    output tbr_pkg::pixel_pos_t     out_pos,
    input  logic                    out_ready
);

    localparam int COORD_MAX = (1 << tbr_pkg::COORD_W) - 1;
    localparam int X_LIM_INT = (IMAGE_WIDTH - 1 < COORD_MAX) ? IMAGE_WIDTH - 1 : COORD_MAX;
    localparam int Y_LIM_INT = (IMAGE_HEIGHT - 1 < COORD_MAX) ? IMAGE_HEIGHT - 1 : COORD_MAX;
    localparam tbr_pkg::coord_t X_LIMIT = tbr_pkg::coord_t'(X_LIM_INT);
    localparam tbr_pkg::coord_t Y_LIMIT = tbr_pkg::coord_t'(Y_LIM_INT);

    tbr_pkg::coord_t     walk_x_reg;
    tbr_pkg::coord_t     walk_y_reg;
    logic                walk_active_reg;
    logic                valid_reg;
    tbr_pkg::pixel_pos_t pos_reg;
    tbr_pkg::pixel_pos_t pos_next;

    tbr_pkg::coord_t     raw_min_x;
    tbr_pkg::coord_t     raw_max_x;
    tbr_pkg::coord_t     raw_min_y;
    tbr_pkg::coord_t     raw_max_y;
    tbr_pkg::coord_t     min_x;
    tbr_pkg::coord_t     max_x;
    tbr_pkg::coord_t     min_y;
    tbr_pkg::coord_t     max_y;
    logic                accept;

    always_comb begin
        raw_min_x = tbr_pkg::min3(cfg.v[0].x, cfg.v[1].x, cfg.v[2].x);
        raw_max_x = tbr_pkg::max3(cfg.v[0].x, cfg.v[1].x, cfg.v[2].x);
        raw_min_y = tbr_pkg::min3(cfg.v[0].y, cfg.v[1].y, cfg.v[2].y);
        raw_max_y = tbr_pkg::max3(cfg.v[0].y, cfg.v[1].y, cfg.v[2].y);
        min_x = (raw_min_x > X_LIMIT) ? X_LIMIT : raw_min_x;
        max_x = (raw_max_x > X_LIMIT) ? X_LIMIT : raw_max_x;
        min_y = (raw_min_y > Y_LIMIT) ? Y_LIMIT : raw_min_y;
        max_y = (raw_max_y > Y_LIMIT) ? Y_LIMIT : raw_max_y;
    end

    always_comb begin
        priority if (in_restart || !walk_active_reg || (walk_y_reg < min_y)
                     || (walk_y_reg > max_y)) begin
            pos_next.x = min_x;
            pos_next.y = min_y;
        end else if ((walk_x_reg < min_x) || (walk_x_reg >= max_x)) begin
            pos_next.x = min_x;
            pos_next.y = (walk_y_reg == max_y) ? min_y : walk_y_reg + 1'b1;
        end else begin
            pos_next.x = walk_x_reg + 1'b1;
            pos_next.y = walk_y_reg;
        end
        pos_next.last = (pos_next.x == max_x) && (pos_next.y == max_y);
    end

    assign in_ready = !valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            walk_x_reg      <= '0;
            walk_y_reg      <= '0;
            walk_active_reg <= 1'b0;
            valid_reg       <= 1'b0;
        end else begin
            if (in_ready) begin
                valid_reg <= in_valid;
            end
            if (accept) begin
                walk_x_reg      <= pos_next.x;
                walk_y_reg      <= pos_next.y;
                walk_active_reg <= !pos_next.last;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pos_reg <= pos_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_pos   = pos_reg;

endmodule

// ===== rtl/tbr_edge_eval.sv =====
// Product stage of the edge functions, one per triangle edge, and of the opposite-vertex value.
module tbr_edge_eval (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  tbr_pkg::tri_cfg_t       cfg,
    input  logic                    in_valid,
    input  tbr_pkg::pixel_pos_t     in_pos,
    output logic                    in_ready,
    output logic                    out_valid,
    output tbr_pkg::edge_stage_t    out_stage,
    input  logic                    out_ready
);

    logic                 valid_reg;
    tbr_pkg::edge_stage_t stage_reg;
    tbr_pkg::edge_stage_t stage_next;

    always_comb begin
        tbr_pkg::diff_t   coef_a;
        tbr_pkg::diff_t   coef_b;
        tbr_pkg::diff_t   d_a;
        tbr_pkg::diff_t   d_b;
        tbr_pkg::vertex_t va;
        tbr_pkg::vertex_t vc;
        stage_next.pos = in_pos;
        for (int k = 0; k < tbr_pkg::NUM_VERT; k++) begin
            va     = cfg.v[tbr_pkg::EDGE_A_IDX[k]];
            vc     = cfg.v[tbr_pkg::EDGE_C_IDX[k]];
            coef_a = tbr_pkg::coord_diff(va.y, vc.y);
            coef_b = tbr_pkg::coord_diff(vc.x, va.x);
            stage_next.edges[k].pa = tbr_pkg::mul(coef_a, tbr_pkg::to_signed(in_pos.x));
            stage_next.edges[k].pb = tbr_pkg::mul(coef_b, tbr_pkg::to_signed(in_pos.y));
            stage_next.edges[k].c1 = tbr_pkg::mul(tbr_pkg::to_signed(va.x),
                                                  tbr_pkg::to_signed(vc.y));
            stage_next.edges[k].c2 = tbr_pkg::mul(tbr_pkg::to_signed(vc.x),
                                                  tbr_pkg::to_signed(va.y));
            stage_next.edges[k].ab_sum = (tbr_pkg::DIFF_W + 1)'(coef_a)
                                       + (tbr_pkg::DIFF_W + 1)'(coef_b);
        end
        d_a = tbr_pkg::coord_diff(cfg.v[1].y, cfg.v[2].y);
        d_b = tbr_pkg::coord_diff(cfg.v[2].x, cfg.v[1].x);
        stage_next.d_pa = tbr_pkg::mul(d_a, tbr_pkg::to_signed(cfg.v[0].x));
        stage_next.d_pb = tbr_pkg::mul(d_b, tbr_pkg::to_signed(cfg.v[0].y));
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            stage_reg <= stage_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

endmodule

// ===== rtl/tbr_cover.sv =====
// Edge sums, coverage sign tests and the result register.
module tbr_cover (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  tbr_pkg::tri_cfg_t       cfg,
    input  logic                    in_valid,
    input  tbr_pkg::edge_stage_t    in_stage,
    output logic                    in_ready,
    output logic                    out_valid,
    output tbr_pkg::pixel_out_t     out_pix,
    input  logic                    out_ready
);

    logic                valid_reg;
    tbr_pkg::pixel_out_t pix_reg;
    tbr_pkg::pixel_out_t pix_next;
    tbr_pkg::edge_t      d_val;
    logic                covered;

    always_comb begin
        tbr_pkg::edge_t e_val;
        tbr_pkg::edge_t off_val;
        d_val   = tbr_pkg::edge_sum(in_stage.d_pa, in_stage.d_pb,
                                    in_stage.edges[0].c1, in_stage.edges[0].c2);
        covered = (d_val != '0);
        for (int k = 0; k < tbr_pkg::NUM_VERT; k++) begin
            e_val   = tbr_pkg::edge_sum(in_stage.edges[k].pa, in_stage.edges[k].pb,
                                        in_stage.edges[k].c1, in_stage.edges[k].c2);
            off_val = tbr_pkg::edge_offscreen(in_stage.edges[k].c1, in_stage.edges[k].c2,
                                              in_stage.edges[k].ab_sum);
            covered = covered && tbr_pkg::edge_ok(e_val, d_val, off_val);
        end
        pix_next.x       = in_stage.pos.x;
        pix_next.y       = in_stage.pos.y;
        pix_next.covered = covered;
        pix_next.color   = cfg.color;
        pix_next.last    = in_stage.pos.last;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            pix_reg <= pix_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_pix   = pix_reg;

endmodule

// ===== rtl/triangle_bbox_rasterizer_unit.sv =====
// Top level of the triangle bounding-box rasterizer.
// The three vertices and the fill color (reset to 0) are set through the write port
// (cfg_wr_en, cfg_wr_index, cfg_wr_data) by the user only while no request is in flight;
// the block does not enforce it. Each request on the s_ channel carries a restart flag
// in s_tdata[0] and yields one pixel on the m_ channel: the next pixel of the triangle's
// bounding box in row-major order, its coverage flag on m_tuser, the fill color, and
// m_tlast on the box's final pixel. A request with restart set, the first request after
// reset and the request after a last pixel all begin again at the box's top-left corner.
// The block is a three-stage pipeline: walker register, edge product register and
// result register. An accepted request passes through the walker, edge product and
// result registers before m_tvalid rises, and a new request is taken every cycle unless
// a stall has filled every stage. When the receiver stalls, the result register holds its
// pixel and earlier stages keep filling until every stage is occupied, then s_tready falls.
// Synchronous reset empties the pipeline and sets the walk back to its not-started state.
module triangle_bbox_rasterizer_unit #(
    parameter int IMAGE_WIDTH  = 512,
    parameter int IMAGE_HEIGHT = 512
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [tbr_pkg::CFG_IDX_W-1:0]       cfg_wr_index,
    input  logic [tbr_pkg::CFG_DATA_W-1:0]      cfg_wr_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // s_tdata: restart [0], zero [7:1].
    input  logic [tbr_pkg::S_TDATA_W-1:0]       s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // m_tdata: pixel_x [8:0], pixel_y [17:9], pixel_color [41:18], zero [47:42].
    output logic [tbr_pkg::M_TDATA_W-1:0]       m_tdata,
    // m_tuser: covered [0].
    output logic [0:0]                          m_tuser,
    output logic                                m_tlast
);

    tbr_pkg::tri_cfg_t    cfg;
    logic                 walk_valid;
    logic                 walk_ready;
    tbr_pkg::pixel_pos_t  walk_pos;
    logic                 edge_valid;
    logic                 edge_ready;
    tbr_pkg::edge_stage_t edge_stage;
    tbr_pkg::pixel_out_t  out_pix;

    tbr_cfg_regs u_cfg_regs (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .cfg          (cfg)
    );

    tbr_walker #(
        .IMAGE_WIDTH  (IMAGE_WIDTH),
        .IMAGE_HEIGHT (IMAGE_HEIGHT)
    ) u_walker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .in_valid   (s_tvalid),
        .in_restart (s_tdata[0]),
        .in_ready   (s_tready),
        .out_valid  (walk_valid),
        .out_pos    (walk_pos),
        .out_ready  (walk_ready)
    );

    tbr_edge_eval u_edge_eval (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (walk_valid),
        .in_pos    (walk_pos),
        .in_ready  (walk_ready),
        .out_valid (edge_valid),
        .out_stage (edge_stage),
        .out_ready (edge_ready)
    );

    tbr_cover u_cover (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (edge_valid),
        .in_stage  (edge_stage),
        .in_ready  (edge_ready),
        .out_valid (m_tvalid),
        .out_pix   (out_pix),
        .out_ready (m_tready)
    );

    assign m_tdata = {6'd0, out_pix.color, out_pix.y, out_pix.x};
    assign m_tuser = out_pix.covered;
    assign m_tlast = out_pix.last;

    // An empty result register must leave the whole pipeline open.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("pipeline blocked while result register is empty");

    // Every accepted request lands in the walker stage.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> walk_valid)
        else $error("accepted request missing from walker stage");

    // A walker pixel that the product stage cannot take is held unchanged.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (walk_valid && !walk_ready) |=> (walk_valid && $stable(walk_pos)))
        else $error("stalled walker pixel changed");

endmodule
